// File: rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // largest alignment exponent honored, larger requests are capped
  localparam logic [3:0] ALIGN_LOG2_MAX = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_WALK,
    ST_A_SLOT,
    ST_A_COMMIT,
    ST_F_RD,
    ST_F_CMP,
    ST_F_WALK,
    ST_F_COMMIT,
    ST_RESULT
  } ffa_state_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOFIT   = 2'd1,
    STAT_UNKNOWN = 2'd2,
    STAT_FULL    = 2'd3
  } ffa_status_e;

  typedef struct packed {
    logic        load;
    logic        idx_clr;
    logic        idx_inc;
    logic        seg_hit;
    logic        slot_hit;
    logic        alloc_commit;
    logic        rec_hit;
    logic        walk_inc;
    logic        walk_stop;
    logic        free_commit;
    logic        set_status;
    ffa_status_e status;
    logic        out_load;
  } ffa_cmd_t;

  typedef struct packed {
    logic req_free;
    logic req_zero;
    logic seg_end;
    logic seg_fit;
    logic slot_free;
    logic slot_end;
    logic rec_match;
    logic walk_more;
    logic free_full;
    logic out_room;
  } ffa_sts_t;

endpackage

// File: rtl/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Request sequencer: walks the segment table and record table through the
// datapath and decides the outcome of each request.
// ----------------------------------------------------------------------------
module ffa_ctrl
  import ffa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_axis_tvalid,
  output logic     s_axis_tready,
  input  ffa_sts_t sts_i,
  output ffa_cmd_t cmd_o
);

  ffa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.status  = STAT_OK;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          if (!sts_i.req_free) begin
            state_d = ST_A_WALK;
          end else if (sts_i.req_zero) begin
            cmd_o.set_status = 1'b1;
            state_d          = ST_RESULT;
          end else begin
            state_d = ST_F_RD;
          end
        end
      end
      ST_A_WALK: begin
        if (sts_i.seg_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STAT_NOFIT;
          state_d          = ST_RESULT;
        end else if (sts_i.seg_fit) begin
          cmd_o.seg_hit = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_A_SLOT;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_A_SLOT: begin
        if (sts_i.slot_free) begin
          cmd_o.slot_hit = 1'b1;
          state_d        = ST_A_COMMIT;
        end else if (sts_i.slot_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STAT_FULL;
          state_d          = ST_RESULT;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_A_COMMIT: begin
        cmd_o.alloc_commit = 1'b1;
        cmd_o.set_status   = 1'b1;
        state_d            = ST_RESULT;
      end
      ST_F_RD: begin
        state_d = ST_F_CMP;
      end
      ST_F_CMP: begin
        if (sts_i.rec_match) begin
          cmd_o.rec_hit = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_F_WALK;
        end else if (sts_i.slot_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STAT_UNKNOWN;
          state_d          = ST_RESULT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_F_RD;
        end
      end
      ST_F_WALK: begin
        if (sts_i.walk_more) begin
          cmd_o.walk_inc = 1'b1;
          cmd_o.idx_inc  = 1'b1;
        end else begin
          cmd_o.walk_stop = 1'b1;
          state_d         = ST_F_COMMIT;
        end
      end
      ST_F_COMMIT: begin
        cmd_o.set_status = 1'b1;
        if (sts_i.free_full) begin
          cmd_o.status = STAT_FULL;
        end else begin
          cmd_o.free_commit = 1'b1;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_room) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ffa_datapath.sv
// ----------------------------------------------------------------------------
// ffa_datapath
// Segment table, allocation records, counters and the result register.
// ----------------------------------------------------------------------------
module ffa_datapath
  import ffa_pkg::*;
#(
  parameter int MAX_FREE_SEGMENTS = 32,
  parameter int MAX_ALLOCATIONS   = 64,
  parameter int HEADER_BYTES      = 16,
  parameter int MIN_SPLIT_BYTES   = 16,
  parameter int ADDR_BITS         = 20,
  localparam int LW     = ADDR_BITS + 1,
  localparam int CW     = $clog2(MAX_ALLOCATIONS + 1),
  localparam int IN_DW  = ((LW + 4 + ADDR_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((ADDR_BITS + LW + CW + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LW-1:0]     cfg_wdata_i,
  input  logic [IN_DW-1:0]  s_axis_tdata,
  input  logic              s_axis_tuser,
  input  ffa_cmd_t          cmd_i,
  output ffa_sts_t          sts_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,
  output logic [1:0]        m_axis_tuser
);

  localparam int AB   = ADDR_BITS;
  localparam int MS   = MAX_FREE_SEGMENTS;
  localparam int MA   = MAX_ALLOCATIONS;
  localparam int TW   = AB + 2;
  localparam int XW   = AB + 14;
  localparam int OW   = $clog2(HEADER_BYTES + 4096);
  localparam int SW   = $clog2(MS);
  localparam int CNW  = $clog2(MS + 1);
  localparam int RW   = (MA > 1) ? $clog2(MA) : 1;
  localparam int IW   = (CNW > RW) ? CNW : RW;
  localparam int RECW = AB + LW + OW;
  localparam logic [LW-1:0] POOL_MIN = LW'(32);
  localparam logic [LW-1:0] POOL_MAX = {1'b1, {AB{1'b0}}};
  localparam logic [LW-1:0] POOL_RST = (AB >= 16) ? LW'(65536) : POOL_MAX;

  // request fields
  logic [LW-1:0] req_q;
  logic [3:0]    lg_q;
  logic [AB-1:0] faddr_q;
  logic [3:0]    in_lg;

  logic [IW-1:0] idx_q;

  logic [AB-1:0]  seg_start_q [MS];
  logic [LW-1:0]  seg_len_q   [MS];
  logic [CNW-1:0] seg_cnt_q;

  logic [SW-1:0]  sidx_q;
  logic [AB-1:0]  s_q;
  logic [LW-1:0]  l_q;
  logic [OW-1:0]  off_q;
  logic [TW-1:0]  tot_q;
  logic [RW-1:0]  slot_q;

  logic [AB-1:0]  bstart_q;
  logic [LW-1:0]  bend_q;
  logic [AB-1:0]  prev_start_q;
  logic [LW-1:0]  prev_len_q;
  logic           have_prev_q;
  logic           mprev_q, mnext_q;
  logic [CNW-1:0] p_q;
  logic [LW-1:0]  next_len_q;

  logic [MA-1:0]   rec_valid_q;
  logic [RECW-1:0] rec_mem [MA];
  logic [RECW-1:0] rec_rd_q;

  logic [LW-1:0]   used_q;
  logic [CW-1:0]   live_q;
  ffa_status_e     stat_q;
  logic [AB-1:0]   grant_q;

  logic            m_valid_q;
  logic [AB-1:0]   m_grant_q;
  ffa_status_e     m_stat_q;
  logic [LW-1:0]   m_used_q;
  logic [CW-1:0]   m_live_q;

  // current table entry
  logic [SW-1:0] seg_sel;
  logic [RW-1:0] rsel;
  logic [AB-1:0] cur_start;
  logic [LW-1:0] cur_len;
  logic          in_range;
  logic [XW-1:0] a_mask, a_sum, a_aligned;
  logic [OW-1:0] off_w;
  logic [TW-1:0] tot_w;

  // record read fields
  logic [AB-1:0] rd_addr;
  logic [LW-1:0] rd_total;
  logic [OW-1:0] rd_off;
  logic [AB-1:0] rd_bstart;

  // commit values
  logic [AB-1:0]  grant_w;
  logic [TW-1:0]  rem_w;
  logic           whole_w;
  logic [LW-1:0]  take_w;
  logic [CNW-1:0] pm1;
  logic [LW-1:0]  pool_w;
  logic [LW-1:0]  prev_end_w;

  assign in_lg     = s_axis_tdata[LW +: 4];
  assign seg_sel   = idx_q[SW-1:0];
  assign rsel      = idx_q[RW-1:0];
  assign cur_start = seg_start_q[seg_sel];
  assign cur_len   = seg_len_q[seg_sel];
  assign in_range  = idx_q < IW'(seg_cnt_q);

  assign a_mask    = (XW'(1) << lg_q) - XW'(1);
  assign a_sum     = XW'(cur_start) + XW'(HEADER_BYTES) + a_mask;
  assign a_aligned = a_sum & ~a_mask;
  assign off_w     = OW'(a_aligned - XW'(cur_start));
  assign tot_w     = TW'(req_q) + TW'(off_w);

  assign rd_off    = rec_rd_q[OW-1:0];
  assign rd_total  = rec_rd_q[OW +: LW];
  assign rd_addr   = rec_rd_q[OW+LW +: AB];
  assign rd_bstart = faddr_q - AB'(rd_off);

  assign grant_w = s_q + AB'(off_q);
  assign rem_w   = TW'(l_q) - tot_q;
  assign whole_w = rem_w <= TW'(MIN_SPLIT_BYTES);
  assign take_w  = whole_w ? l_q : LW'(tot_q);
  assign pm1     = p_q - CNW'(1);
  assign prev_end_w = LW'(prev_start_q) + prev_len_q;

  always_comb begin
    if (cfg_wdata_i < POOL_MIN) begin
      pool_w = POOL_MIN;
    end else if (cfg_wdata_i > POOL_MAX) begin
      pool_w = POOL_MAX;
    end else begin
      pool_w = cfg_wdata_i;
    end
  end

  assign sts_o.req_free  = s_axis_tuser;
  assign sts_o.req_zero  = s_axis_tdata[LW+4 +: AB] == '0;
  assign sts_o.seg_end   = !in_range;
  assign sts_o.seg_fit   = TW'(cur_len) >= tot_w;
  assign sts_o.slot_free = !rec_valid_q[rsel];
  assign sts_o.slot_end  = idx_q == IW'(MA - 1);
  assign sts_o.rec_match = rec_valid_q[rsel] && (rd_addr == faddr_q);
  assign sts_o.walk_more = in_range && (LW'(cur_start) < bend_q);
  assign sts_o.free_full = !mprev_q && !mnext_q && (seg_cnt_q >= CNW'(MS));
  assign sts_o.out_room  = !m_valid_q || m_axis_tready;

  // request capture and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= s_axis_tdata[LW-1:0];
      lg_q    <= (in_lg > ALIGN_LOG2_MAX) ? ALIGN_LOG2_MAX : in_lg;
      faddr_q <= s_axis_tdata[LW+4 +: AB];
    end
    if (cmd_i.seg_hit) begin
      sidx_q <= seg_sel;
      s_q    <= cur_start;
      l_q    <= cur_len;
      off_q  <= off_w;
      tot_q  <= tot_w;
    end
    if (cmd_i.slot_hit) begin
      slot_q <= rsel;
    end
    if (cmd_i.rec_hit) begin
      slot_q      <= rsel;
      tot_q       <= TW'(rd_total);
      bstart_q    <= rd_bstart;
      bend_q      <= LW'(rd_bstart) + rd_total;
      have_prev_q <= 1'b0;
    end
    if (cmd_i.walk_inc) begin
      prev_start_q <= cur_start;
      prev_len_q   <= cur_len;
      have_prev_q  <= 1'b1;
    end
    if (cmd_i.walk_stop) begin
      p_q        <= CNW'(idx_q);
      mprev_q    <= have_prev_q && (prev_end_w == LW'(bstart_q));
      mnext_q    <= in_range && (LW'(cur_start) == bend_q);
      next_len_q <= cur_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  // free segment table, a shift moves all entries past the position at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MS; k++) begin
        seg_start_q[k] <= '0;
        seg_len_q[k]   <= '0;
      end
      seg_len_q[0] <= POOL_RST;
      seg_cnt_q    <= CNW'(1);
    end else if (cfg_we_i) begin
      seg_start_q[0] <= '0;
      seg_len_q[0]   <= pool_w;
      seg_cnt_q      <= CNW'(1);
    end else if (cmd_i.alloc_commit) begin
      if (whole_w) begin
        for (int k = 0; k < MS - 1; k++) begin
          if (k >= int'(sidx_q)) begin
            seg_start_q[k] <= seg_start_q[k+1];
            seg_len_q[k]   <= seg_len_q[k+1];
          end
        end
        seg_cnt_q <= seg_cnt_q - CNW'(1);
      end else begin
        seg_start_q[sidx_q] <= AB'(s_q + AB'(tot_q));
        seg_len_q[sidx_q]   <= LW'(rem_w);
      end
    end else if (cmd_i.free_commit) begin
      if (mprev_q && mnext_q) begin
        for (int k = 0; k < MS - 1; k++) begin
          if (k >= int'(p_q)) begin
            seg_start_q[k] <= seg_start_q[k+1];
            seg_len_q[k]   <= seg_len_q[k+1];
          end
        end
        seg_len_q[pm1[SW-1:0]] <= prev_len_q + LW'(tot_q) + next_len_q;
        seg_cnt_q <= seg_cnt_q - CNW'(1);
      end else if (mprev_q) begin
        seg_len_q[pm1[SW-1:0]] <= prev_len_q + LW'(tot_q);
      end else if (mnext_q) begin
        seg_start_q[p_q[SW-1:0]] <= bstart_q;
        seg_len_q[p_q[SW-1:0]]   <= next_len_q + LW'(tot_q);
      end else begin
        for (int k = 1; k < MS; k++) begin
          if (k > int'(p_q)) begin
            seg_start_q[k] <= seg_start_q[k-1];
            seg_len_q[k]   <= seg_len_q[k-1];
          end
        end
        seg_start_q[p_q[SW-1:0]] <= bstart_q;
        seg_len_q[p_q[SW-1:0]]   <= LW'(tot_q);
        seg_cnt_q <= seg_cnt_q + CNW'(1);
      end
    end
  end

  // allocation records: address, total, offset
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_commit) begin
      rec_mem[slot_q] <= {grant_w, take_w, off_q};
    end
    rec_rd_q <= rec_mem[rsel];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= '0;
      used_q      <= '0;
      live_q      <= '0;
    end else if (cfg_we_i) begin
      rec_valid_q <= '0;
      used_q      <= '0;
      live_q      <= '0;
    end else if (cmd_i.alloc_commit) begin
      rec_valid_q[slot_q] <= 1'b1;
      used_q <= used_q + take_w;
      live_q <= live_q + CW'(1);
    end else if (cmd_i.free_commit) begin
      rec_valid_q[slot_q] <= 1'b0;
      used_q <= used_q - LW'(tot_q);
      live_q <= live_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_status) begin
      stat_q  <= cmd_i.status;
      grant_q <= cmd_i.alloc_commit ? grant_w : '0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_grant_q <= grant_q;
      m_stat_q  <= stat_q;
      m_used_q  <= used_q;
      m_live_q  <= live_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DW'({m_live_q, m_used_q, m_grant_q});
  assign m_axis_tuser  = m_stat_q;

endmodule

// File: rtl/first_fit_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// First-fit allocator over a byte pool with split and coalescing on free.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis stream: tuser selects allocate (0) or free (1),
// tdata carries size, alignment exponent and the address to free. Each request
// yields one result on m_axis: granted address, used bytes and live count in
// tdata, status code in tuser. cfg_we_i with cfg_wdata_i sets the pool size
// (clamped) and resets all bookkeeping; write it only while the unit is idle.
// One request is processed at a time. An allocate scans the segment table
// for the first segment that fits, then the record slots for the first free
// one, then commits. A free reads and compares each record in the record
// memory in turn, a read state and a compare state per record, until the
// address matches, then walks the segment table to the block's position
// and commits. A free of address zero goes straight to the result.
// The result register lets the next request be taken while a result waits;
// if the receiver stalls, that next request completes and holds until the
// result register drains. After reset the pool is one 65536-byte segment.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_unit
  import ffa_pkg::*;
#(
  parameter int MAX_FREE_SEGMENTS = 32,
  parameter int MAX_ALLOCATIONS   = 64,
  parameter int HEADER_BYTES      = 16,
  parameter int MIN_SPLIT_BYTES   = 16,
  parameter int ADDR_BITS         = 20,
  localparam int LW     = ADDR_BITS + 1,
  localparam int CW     = $clog2(MAX_ALLOCATIONS + 1),
  localparam int IN_DW  = ((LW + 4 + ADDR_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((ADDR_BITS + LW + CW + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LW-1:0]     cfg_wdata_i,    // pool_bytes
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // request_bytes, align_log2, free_address
  input  logic              s_axis_tuser,   // op
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // granted_address, bytes_in_use, live_allocations
  output logic [1:0]        m_axis_tuser    // status
);

  ffa_cmd_t cmd;
  ffa_sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  ffa_datapath #(
    .MAX_FREE_SEGMENTS (MAX_FREE_SEGMENTS),
    .MAX_ALLOCATIONS   (MAX_ALLOCATIONS),
    .HEADER_BYTES      (HEADER_BYTES),
    .MIN_SPLIT_BYTES   (MIN_SPLIT_BYTES),
    .ADDR_BITS         (ADDR_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: rtl/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffa_checker
  import ffa_pkg::*;
#(
  parameter int MAX_ALLOCATIONS = 64,
  parameter int ADDR_BITS       = 20,
  localparam int LW     = ADDR_BITS + 1,
  localparam int CW     = $clog2(MAX_ALLOCATIONS + 1),
  localparam int OUT_DW = ((ADDR_BITS + LW + CW + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_DW-1:0] m_axis_tdata,
  input logic [1:0]        m_axis_tuser
);

  // one request in flight: the port closes right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // only a granted allocate carries an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tdata[ADDR_BITS-1:0] == '0)
    else $error("address on failed request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ADDR_BITS+LW +: CW] <= CW'(MAX_ALLOCATIONS))
    else $error("live count above record capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind first_fit_free_list_allocator_unit ffa_checker #(
  .MAX_ALLOCATIONS (MAX_ALLOCATIONS),
  .ADDR_BITS       (ADDR_BITS)
) u_ffa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
